[hdl/lpb_pkg.sv]
// Shared types and constants for the long-press mode button block.
// No dependencies; imported by lpb_core and the top level.
package lpb_pkg;

  localparam int unsigned TICK_W    = 10;
  localparam int unsigned HOLD_W    = 16;
  localparam int unsigned COUNT_W   = 18;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [HOLD_W-1:0] HOLD_MAX        = 16'hFFFF;
  localparam logic [HOLD_W-1:0] BLINK_MIN_REQ   = 16'd100;
  localparam logic [HOLD_W-1:0] BLINK_MIN_HALF  = 16'd50;

  localparam logic [TICK_W-1:0] TICK_RESET      = 10'd100;
  localparam logic [HOLD_W-1:0] CONFIG_RESET    = 16'd3000;
  localparam logic [HOLD_W-1:0] FACTORY_RESET   = 16'd10000;
  localparam logic [HOLD_W-1:0] BLINK_RESET     = 16'd500;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_TICK    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CONFIG  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FACTORY = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BLINK   = 2'd3;

  // Hold mode, which is also the action code reported on release.
  typedef enum logic [1:0] {
    MODE_NONE    = 2'd0,
    MODE_CONFIG  = 2'd1,
    MODE_FACTORY = 2'd2
  } mode_t;

  typedef struct packed {
    logic [TICK_W-1:0] tick_ms;
    logic [HOLD_W-1:0] config_hold_ms;
    logic [HOLD_W-1:0] factory_hold_ms;
    logic [HOLD_W-1:0] blink_request_ms;
  } cfg_t;

  typedef struct packed {
    logic              led_level;
    logic [1:0]        action;
    logic [HOLD_W-1:0] hold_ms;
  } result_t;

endpackage

[hdl/lpb_core.sv]
// Per-tick state update: LED blinker, hold timer and hold mode selection.
// Depends on lpb_pkg; the result of each tick is handed to the top level.
module lpb_core (
  input  logic           clk,
  input  logic           rst,
  input  logic           step,
  input  logic           pressed,
  input  lpb_pkg::cfg_t  cfg,
  output lpb_pkg::result_t result
);
  import lpb_pkg::*;

  logic                      was_pressed, was_pressed_next;
  logic [HOLD_W-1:0]         hold_count, hold_count_next;
  mode_t                     hold_mode, hold_mode_next;
  logic                      blink_enabled, blink_enabled_next;
  logic                      toggle_value, toggle_value_next;
  logic                      pin_level, pin_level_next;
  logic signed [COUNT_W-1:0] blink_countdown, blink_countdown_next;
  logic [HOLD_W-1:0]         half_period, half_period_next;
  logic [HOLD_W:0]           hold_sum;
  logic [1:0]                action_next;

  assign hold_sum = {1'b0, hold_count} + {{(HOLD_W+1-TICK_W){1'b0}}, cfg.tick_ms};

  always_comb begin
    was_pressed_next     = was_pressed;
    hold_count_next      = hold_count;
    hold_mode_next       = hold_mode;
    blink_enabled_next   = blink_enabled;
    toggle_value_next    = toggle_value;
    pin_level_next       = pin_level;
    blink_countdown_next = blink_countdown;
    half_period_next     = half_period;
    action_next          = MODE_NONE;

    // Blinker runs first, on the state left by the previous tick.
    if (blink_enabled) begin
      if (blink_countdown > 0) begin
        blink_countdown_next = blink_countdown -
          $signed({{(COUNT_W-TICK_W){1'b0}}, cfg.tick_ms});
      end else begin
        pin_level_next       = ~toggle_value;
        toggle_value_next    = ~toggle_value;
        blink_countdown_next = $signed({{(COUNT_W-HOLD_W){1'b0}}, half_period});
      end
    end

    // The hold count restarts on both edges of the button.
    if (pressed) begin
      if (!was_pressed) begin
        hold_count_next  = '0;
        was_pressed_next = 1'b1;
      end else if (hold_sum[HOLD_W]) begin
        hold_count_next = HOLD_MAX;
      end else begin
        hold_count_next = hold_sum[HOLD_W-1:0];
      end
    end else if (was_pressed) begin
      hold_count_next  = '0;
      was_pressed_next = 1'b0;
    end

    if (hold_count_next != '0) begin
      if (hold_count_next > cfg.factory_hold_ms) begin
        if (hold_mode != MODE_FACTORY) begin
          hold_mode_next     = MODE_FACTORY;
          pin_level_next     = 1'b0;
          blink_enabled_next = 1'b0;
        end
      end else if (hold_count_next > cfg.config_hold_ms) begin
        if (hold_mode != MODE_CONFIG) begin
          hold_mode_next     = MODE_CONFIG;
          blink_enabled_next = 1'b1;
          toggle_value_next  = 1'b0;
          half_period_next   = (cfg.blink_request_ms > BLINK_MIN_REQ) ?
                               {1'b0, cfg.blink_request_ms[HOLD_W-1:1]} : BLINK_MIN_HALF;
        end
      end
    end else begin
      action_next    = hold_mode;
      hold_mode_next = MODE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      was_pressed     <= 1'b0;
      hold_count      <= '0;
      hold_mode       <= MODE_NONE;
      blink_enabled   <= 1'b0;
      toggle_value    <= 1'b0;
      pin_level       <= 1'b1;
      blink_countdown <= '0;
      half_period     <= '0;
    end else if (step) begin
      was_pressed     <= was_pressed_next;
      hold_count      <= hold_count_next;
      hold_mode       <= hold_mode_next;
      blink_enabled   <= blink_enabled_next;
      toggle_value    <= toggle_value_next;
      pin_level       <= pin_level_next;
      blink_countdown <= blink_countdown_next;
      half_period     <= half_period_next;
    end
  end

  assign result.led_level = pin_level_next;
  assign result.action    = action_next;
  assign result.hold_ms   = hold_count_next;

  // Factory mode is entered with blinking off, and blinking stays off until
  // the mode leaves factory.
  a_factory_steady: assert property (@(posedge clk) disable iff (rst)
    hold_mode == MODE_FACTORY |-> !blink_enabled)
    else $error("factory mode with blinking enabled");

  a_config_blinks: assert property (@(posedge clk) disable iff (rst)
    hold_mode == MODE_CONFIG |-> blink_enabled)
    else $error("config mode without blinking");

  a_hold_needs_press: assert property (@(posedge clk) disable iff (rst)
    hold_count != '0 |-> was_pressed)
    else $error("hold count running while released");

  // A countdown only steps down while positive, so it never goes below
  // minus one tick length.
  a_countdown_floor: assert property (@(posedge clk) disable iff (rst)
    blink_countdown > -18'sd1024)
    else $error("blink countdown underflow");

endmodule

[hdl/long_press_mode_button_with_blink_led.sv]
// Top level of the long-press mode button: configuration registers,
// request handshake and result register. Depends on lpb_pkg and lpb_core.
//
// Each request is one timer tick carrying the raw, active-low button level and
// produces exactly one result: LED drive, release action and hold time. A tick
// is processed combinationally between the state registers and the result
// register, so one request is taken every clock cycle; in_ready drops only when
// a result is waiting and out_ready is low. Configuration is written through a
// plain write port and takes effect for the next request.
module long_press_mode_button_with_blink_led (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic                           button_level,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           led_level,
  output logic [1:0]                     action,
  output logic [lpb_pkg::HOLD_W-1:0]     hold_ms,
  input  logic                           cfg_write,
  input  logic [lpb_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lpb_pkg::HOLD_W-1:0]     cfg_data
);
  import lpb_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_reg;
  logic    step;

  assign in_ready = !out_valid || out_ready;
  assign step     = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.tick_ms          <= TICK_RESET;
      cfg.config_hold_ms   <= CONFIG_RESET;
      cfg.factory_hold_ms  <= FACTORY_RESET;
      cfg.blink_request_ms <= BLINK_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_TICK:    cfg.tick_ms          <= cfg_data[TICK_W-1:0];
        REG_CONFIG:  cfg.config_hold_ms   <= cfg_data;
        REG_FACTORY: cfg.factory_hold_ms  <= cfg_data;
        REG_BLINK:   cfg.blink_request_ms <= cfg_data;
        default:     cfg.tick_ms          <= cfg.tick_ms;
      endcase
    end
  end

  lpb_core u_core (
    .clk     (clk),
    .rst     (rst),
    .step    (step),
    .pressed (!button_level),
    .cfg     (cfg),
    .result  (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (step) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      out_reg <= result;
    end
  end

  assign led_level = out_reg.led_level;
  assign action    = out_reg.action;
  assign hold_ms   = out_reg.hold_ms;

endmodule
